// ----- hdl/pid_speed_controller_defines.svh -----
// Assertion macros shared by the pid_speed_controller RTL.
// Each macro expects clk and rst in scope of the using module.
`ifndef PID_SPEED_CONTROLLER_DEFINES_SVH
`define PID_SPEED_CONTROLLER_DEFINES_SVH

// Plain property checked on every clock outside reset.
`define PIDSC_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Same-cycle implication.
`define PIDSC_ASSERT_IMPL(name, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// Next-cycle implication.
`define PIDSC_ASSERT_NEXT(name, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

// ----- hdl/pidsc_pkg.sv -----
// Package for the PID speed controller: widths, register indexes, codes and
// the configuration struct. No dependencies.
package pidsc_pkg;

  localparam int DEF_SAMPLE_WIDTH = 16;
  localparam int DEF_FRAC_BITS    = 8;

  localparam int GAIN_W        = 16;
  localparam int LIMIT_W       = 21;
  localparam int DRIVE_W       = 22;
  localparam int SUM_W         = 32;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 21;
  localparam int DRIVE_TDATA_W = 24;

  // Default output bound, whole units before scaling by the fraction bits
  localparam int DRIVE_LIMIT_UNITS = 6500;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN_P    = 3'd0,
    REG_GAIN_I    = 3'd1,
    REG_GAIN_D    = 3'd2,
    REG_MODE      = 3'd3,
    REG_DRV_LIMIT = 3'd4,
    REG_INT_LIMIT = 3'd5
  } cfg_reg_e;

  localparam logic OP_STEP  = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  localparam logic MODE_INCR = 1'b0;
  localparam logic MODE_POS  = 1'b1;

  typedef struct packed {
    logic [GAIN_W-1:0]  gain_p;
    logic [GAIN_W-1:0]  gain_i;
    logic [GAIN_W-1:0]  gain_d;
    logic               mode;
    logic [LIMIT_W-1:0] drive_limit;
    logic [LIMIT_W-1:0] int_limit;
  } cfg_t;

endpackage

// ----- hdl/pidsc_cfg.sv -----
// Configuration register file of the PID speed controller.
// Depends on pidsc_pkg.
module pidsc_cfg import pidsc_pkg::*; #(
  parameter int FRAC_BITS = DEF_FRAC_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg
);

  localparam logic [63:0]        LIM_FULL = 64'(DRIVE_LIMIT_UNITS) << FRAC_BITS;
  localparam logic [LIMIT_W-1:0] LIM_RST  = LIM_FULL[LIMIT_W-1:0];
  localparam logic [LIMIT_W-1:0] ITL_RST  = LIMIT_W'(1) << (FRAC_BITS - 1);

  cfg_t regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.gain_p      <= '0;
      regs.gain_i      <= '0;
      regs.gain_d      <= '0;
      regs.mode        <= MODE_INCR;
      regs.drive_limit <= LIM_RST;
      regs.int_limit   <= ITL_RST;
    end else if (cfg_we) begin
      case (cfg_reg_e'(cfg_index))
        REG_GAIN_P:    regs.gain_p      <= cfg_data[GAIN_W-1:0];
        REG_GAIN_I:    regs.gain_i      <= cfg_data[GAIN_W-1:0];
        REG_GAIN_D:    regs.gain_d      <= cfg_data[GAIN_W-1:0];
        REG_MODE:      regs.mode        <= cfg_data[0];
        REG_DRV_LIMIT: regs.drive_limit <= cfg_data[LIMIT_W-1:0];
        REG_INT_LIMIT: regs.int_limit   <= cfg_data[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = regs;

endmodule

// ----- hdl/pidsc_core.sv -----
// PID datapath and kept loop state: error, products, integral clamp and
// output clamp for one item. Depends on pidsc_pkg and the assertion macros.
`include "pid_speed_controller_defines.svh"

module pidsc_core import pidsc_pkg::*; #(
  parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           step,
  input  logic                           op,
  input  logic signed [SAMPLE_WIDTH-1:0] measured,
  input  logic signed [SAMPLE_WIDTH-1:0] target,
  input  cfg_t                           cfg,
  output logic        [DRIVE_W-1:0]      drive,
  output logic                           limited
);

  localparam int EW   = SAMPLE_WIDTH + 1;
  localparam int DW   = SAMPLE_WIDTH + 2;
  localparam int SDW  = SAMPLE_WIDTH + 3;
  localparam int SUMW = ((EW > SUM_W) ? EW : SUM_W) + 1;
  localparam int RAWW = GAIN_W + SAMPLE_WIDTH + 5;
  localparam int IPW  = GAIN_W + SUM_W;

  localparam logic signed [SUMW-1:0] SUM_HI = SUMW'(64'sd2147483647);
  localparam logic signed [SUMW-1:0] SUM_LO = SUMW'(-64'sd2147483648);

  logic signed [EW-1:0]      prev_error;
  logic signed [DW-1:0]      prev_delta;
  logic signed [SUM_W-1:0]   error_sum;
  logic signed [DRIVE_W-1:0] drive_acc;

  logic signed [GAIN_W-1:0]  gp, gi, gd;
  logic signed [EW-1:0]      err;
  logic signed [DW-1:0]      delta;
  logic signed [SDW-1:0]     second;
  logic signed [GAIN_W+DW-1:0]  prod_pd, prod_dd;
  logic signed [GAIN_W+EW-1:0]  prod_ie, prod_pe;
  logic signed [GAIN_W+SDW-1:0] prod_ds;
  logic signed [RAWW-1:0]    raw_inc, raw_pos, raw, lim_s, drive_w;
  logic signed [SUMW-1:0]    sum_wide;
  logic signed [SUM_W-1:0]   sum_sat;
  logic signed [IPW-1:0]     prod_is, itl_s, iterm_w;
  logic signed [LIMIT_W:0]   iterm;
  logic                      hit;
  logic                      is_clear;

  assign gp = $signed(cfg.gain_p);
  assign gi = $signed(cfg.gain_i);
  assign gd = $signed(cfg.gain_d);
  assign is_clear = (op == OP_CLEAR);

  always_comb begin
    err    = EW'(target) - EW'(measured);
    delta  = DW'(err) - DW'(prev_error);
    second = SDW'(delta) - SDW'(prev_delta);

    // incremental form: kept drive plus the three increments
    prod_pd = gp * delta;
    prod_ie = gi * err;
    prod_ds = gd * second;
    raw_inc = RAWW'(drive_acc) + RAWW'(prod_pd) + RAWW'(prod_ie) + RAWW'(prod_ds);

    // positional form: running sum saturates at the 32-bit range
    sum_wide = SUMW'(error_sum) + SUMW'(err);
    if (sum_wide > SUM_HI) begin
      sum_sat = SUM_HI[SUM_W-1:0];
    end else if (sum_wide < SUM_LO) begin
      sum_sat = SUM_LO[SUM_W-1:0];
    end else begin
      sum_sat = sum_wide[SUM_W-1:0];
    end
    prod_is = gi * sum_sat;
    itl_s   = $signed({{(IPW-LIMIT_W){1'b0}}, cfg.int_limit});
    if (prod_is > itl_s) begin
      iterm_w = itl_s;
    end else if (prod_is < -itl_s) begin
      iterm_w = -itl_s;
    end else begin
      iterm_w = prod_is;
    end
    iterm   = iterm_w[LIMIT_W:0];
    prod_pe = gp * err;
    prod_dd = gd * delta;
    raw_pos = RAWW'(prod_pe) + RAWW'(iterm) + RAWW'(prod_dd);

    raw   = (cfg.mode == MODE_POS) ? raw_pos : raw_inc;
    lim_s = $signed({{(RAWW-LIMIT_W){1'b0}}, cfg.drive_limit});
    hit   = 1'b0;
    if (raw > lim_s) begin
      drive_w = lim_s;
      hit     = 1'b1;
    end else if (raw < -lim_s) begin
      drive_w = -lim_s;
      hit     = 1'b1;
    end else begin
      drive_w = raw;
    end
  end

  assign drive   = is_clear ? '0 : drive_w[DRIVE_W-1:0];
  assign limited = is_clear ? 1'b0 : hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_error <= '0;
      prev_delta <= '0;
      error_sum  <= '0;
      drive_acc  <= '0;
    end else if (step) begin
      if (is_clear) begin
        prev_error <= '0;
        prev_delta <= '0;
        error_sum  <= '0;
        drive_acc  <= '0;
      end else begin
        prev_error <= err;
        drive_acc  <= drive_w[DRIVE_W-1:0];
        if (cfg.mode == MODE_POS) begin
          error_sum <= sum_sat;
        end else begin
          prev_delta <= delta;
        end
      end
    end
  end

  `PIDSC_ASSERT_IMPL(a_drive_bound, step, (drive_w <= lim_s) && (drive_w >= -lim_s), "drive beyond limit")
  `PIDSC_ASSERT_IMPL(a_hit_at_edge, hit, (drive_w == lim_s) || (drive_w == -lim_s), "limited off edge")
  `PIDSC_ASSERT_NEXT(a_clear_state, step && is_clear, (prev_error == '0) && (prev_delta == '0) && (error_sum == '0) && (drive_acc == '0), "state not cleared")

endmodule

// ----- hdl/pid_speed_controller.sv -----
// PID speed controller for a motor speed loop.
//
// Input stream (s_*): tuser carries op (0 control step, 1 clear all kept
// state), tdata carries measured then target, signed samples. Output stream
// (m_*): tdata carries the signed Q.8 drive, tuser the limited flag. One
// result item leaves for every input item, in order.
// Configuration: cfg_we writes cfg_data into register cfg_index on a rising
// edge (0 gain_p, 1 gain_i, 2 gain_d, 3 mode, 4 drive_limit,
// 5 integral_term_limit); write only while no item is in flight.
// m_tvalid rises after the item passes the input register, which takes it at
// the accepting edge, and the result register, where the whole PID update
// (three parallel multiplies, adds and clamps) lands. Throughput is one item
// per cycle while m_tready is high; the loop state updates in the same cycle
// the result is registered, so the next item sees it.
// When m_tready is low the result holds and one more item can wait in the
// input register; s_tready drops only when both are full.
// Synchronous reset clears the kept state, empties both registers and
// restores the register defaults (limit 6500.0, integral clamp 0.5).
// Depends on pidsc_pkg, pidsc_cfg, pidsc_core and the assertion macros.
`include "pid_speed_controller_defines.svh"

module pid_speed_controller import pidsc_pkg::*; #(
  parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH,
  parameter int FRAC_BITS    = DEF_FRAC_BITS
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     s_tvalid,
  output logic                                     s_tready,
  // [SAMPLE_WIDTH-1:0] measured, [2*SAMPLE_WIDTH-1:SAMPLE_WIDTH] target
  input  logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0]      s_tdata,
  // [0] op
  input  logic                                     s_tuser,
  output logic                                     m_tvalid,
  input  logic                                     m_tready,
  // [21:0] drive
  output logic [DRIVE_TDATA_W-1:0]                 m_tdata,
  // [0] limited
  output logic                                     m_tuser,
  input  logic                                     cfg_we,
  input  logic [CFG_IDX_W-1:0]                     cfg_index,
  input  logic [CFG_DATA_W-1:0]                    cfg_data
);

  cfg_t cfg;

  logic                           in_valid;
  logic                           in_op;
  logic signed [SAMPLE_WIDTH-1:0] in_meas;
  logic signed [SAMPLE_WIDTH-1:0] in_tgt;
  logic                           out_valid;
  logic [DRIVE_W-1:0]             out_drive;
  logic                           out_limited;
  logic [DRIVE_W-1:0]             drive_c;
  logic                           limited_c;
  logic                           advance;

  pidsc_cfg #(
    .FRAC_BITS (FRAC_BITS)
  ) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  pidsc_core #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_core (
    .clk      (clk),
    .rst      (rst),
    .step     (advance),
    .op       (in_op),
    .measured (in_meas),
    .target   (in_tgt),
    .cfg      (cfg),
    .drive    (drive_c),
    .limited  (limited_c)
  );

  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_op   <= s_tuser;
      in_meas <= s_tdata[SAMPLE_WIDTH-1:0];
      in_tgt  <= s_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_drive   <= drive_c;
      out_limited <= limited_c;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {{(DRIVE_TDATA_W-DRIVE_W){1'b0}}, out_drive};
  assign m_tuser  = out_limited;

  `PIDSC_ASSERT_NEXT(a_item_moves, in_valid && !out_valid, out_valid, "item stuck in input stage")
  `PIDSC_ASSERT_IMPL(a_result_source, $rose(out_valid), $past(in_valid), "result without item")

endmodule

// ----- tb/sv/tb_pid_speed_controller.sv -----
// Self-checking testbench for pid_speed_controller: streams speed samples,
// predicts every drive result in both PID forms and compares it field by field.
// Depends on pidsc_pkg and the pid_speed_controller RTL.
module tb_pid_speed_controller;
  import pidsc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SW      = DEF_SAMPLE_WIDTH;
  localparam int S_TDW   = ((2 * SW + 7) / 8) * 8;
  localparam int LIMIT   = 1_500_000;
  localparam int SAT_RUN = 40;
  localparam int SAT_RET = 30;
  localparam longint SUM_HI = 64'sd2147483647;
  localparam longint SUM_LO = -SUM_HI - 1;

  typedef struct {
    logic                 op;
    logic signed [SW-1:0] meas;
    logic signed [SW-1:0] tgt;
  } sample_t;

  typedef struct {
    logic signed [DRIVE_W-1:0] drive;
    logic                      limited;
  } drive_res_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [S_TDW-1:0]      s_tdata = '0;
  logic                  s_tuser = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [DRIVE_TDATA_W-1:0] m_tdata;
  logic                  m_tuser;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  pid_speed_controller dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // controller copy: registers
  logic signed [GAIN_W-1:0] kp = '0, ki = '0, kd = '0;
  logic                     mode_sel = MODE_INCR;
  logic [LIMIT_W-1:0]       drv_lim = LIMIT_W'(DRIVE_LIMIT_UNITS << DEF_FRAC_BITS);
  logic [LIMIT_W-1:0]       int_lim = LIMIT_W'(1 << (DEF_FRAC_BITS - 1));
  // controller copy: loop state
  logic signed [SW:0]        err_prev = '0;
  logic signed [SW+1:0]      delta_prev = '0;
  logic signed [SUM_W-1:0]   err_sum = '0;
  logic signed [DRIVE_W-1:0] drive_acc = '0;

  sample_t    pending[$];
  drive_res_t drive_q[$];
  sample_t    cur_item;
  bit         src_idle = 1'b0, snk_idle = 1'b0;
  int         src_gap = 0, snk_gap = 0;
  int         n_pushed = 0, n_checked = 0, n_clears = 0, n_limited = 0;
  int         n_settings = 0, errors = 0, cycles = 0;

  function automatic drive_res_t pid_step(input sample_t it);
    drive_res_t r;
    longint e, dlt, sec, raw, s, iterm, ilim, dlim;
    r.drive = '0;
    r.limited = 1'b0;
    if (it.op == OP_CLEAR) begin
      err_prev = '0;
      delta_prev = '0;
      err_sum = '0;
      drive_acc = '0;
      return r;
    end
    e = longint'(it.tgt) - longint'(it.meas);
    dlim = longint'(drv_lim);
    ilim = longint'(int_lim);
    if (mode_sel == MODE_INCR) begin
      dlt = e - longint'(err_prev);
      sec = dlt - longint'(delta_prev);
      raw = longint'(drive_acc) + longint'(kp) * dlt + longint'(ki) * e
            + longint'(kd) * sec;
      delta_prev = (SW + 2)'(dlt);
    end else begin
      s = longint'(err_sum) + e;
      if (s > SUM_HI) s = SUM_HI;
      else if (s < SUM_LO) s = SUM_LO;
      err_sum = SUM_W'(s);
      iterm = longint'(ki) * s;
      if (iterm > ilim) iterm = ilim;
      else if (iterm < -ilim) iterm = -ilim;
      raw = longint'(kp) * e + iterm + longint'(kd) * (e - longint'(err_prev));
    end
    err_prev = (SW + 1)'(e);
    // strictly beyond the bound counts as limited
    if (raw > dlim) begin
      raw = dlim;
      r.limited = 1'b1;
    end else if (raw < -dlim) begin
      raw = -dlim;
      r.limited = 1'b1;
    end
    drive_acc = DRIVE_W'(raw);
    r.drive = DRIVE_W'(raw);
    return r;
  endfunction

  task automatic push(input logic op, input logic signed [SW-1:0] m, input logic signed [SW-1:0] t);
    sample_t it;
    it.op = op;
    it.meas = m;
    it.tgt = t;
    pending.push_back(it);
    n_pushed++;
    if (op == OP_CLEAR) n_clears++;
  endtask

  task automatic set_reg(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_GAIN_P:    kp = val[GAIN_W-1:0];
      REG_GAIN_I:    ki = val[GAIN_W-1:0];
      REG_GAIN_D:    kd = val[GAIN_W-1:0];
      REG_MODE:      mode_sel = val[0];
      REG_DRV_LIMIT: drv_lim = val[LIMIT_W-1:0];
      REG_INT_LIMIT: int_lim = val[LIMIT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic end_cfg();
    @(posedge clk);
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  // every item yields one result; then give the pipe some spare time to settle
  task automatic wait_idle();
    while (n_checked != n_pushed) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [GAIN_W-1:0] rand_gain();
    case ($urandom_range(0, 4))
      0: return GAIN_W'($urandom);
      1: return GAIN_W'($urandom_range(0, 600));
      2: return GAIN_W'(0 - $urandom_range(0, 600));
      3: return $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
      default: return '0;
    endcase
  endfunction

  function automatic logic [LIMIT_W-1:0] rand_limit();
    case ($urandom_range(0, 4))
      0: return '0;
      1: return '1;
      2: return LIMIT_W'(1664000);
      3: return LIMIT_W'($urandom);
      default: return LIMIT_W'($urandom_range(1, 8192));
    endcase
  endfunction

  function automatic logic signed [SW-1:0] pick_extreme();
    case ($urandom_range(0, 3))
      0: return 16'sh8000;
      1: return 16'sh7FFF;
      2: return '0;
      default: return -16'sd1;
    endcase
  endfunction

  task automatic push_random();
    logic                 op;
    logic signed [SW-1:0] m, t;
    op = ($urandom_range(0, 39) == 0) ? OP_CLEAR : OP_STEP;
    case ($urandom_range(0, 3))
      0: begin
        m = SW'($urandom);
        t = SW'($urandom);
      end
      1: begin
        // speed tracking its setpoint closely
        t = SW'($urandom);
        m = t + SW'($urandom_range(0, 128)) - SW'(64);
      end
      2: begin
        m = pick_extreme();
        t = pick_extreme();
      end
      default: begin
        m = SW'($urandom_range(0, 600)) - SW'(300);
        t = SW'($urandom_range(0, 600)) - SW'(300);
      end
    endcase
    push(op, m, t);
  endtask

  task automatic report(input string what, input longint want, input longint got);
    errors++;
    if (errors <= 40)
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, want, got);
  endtask

  // source side
  always @(posedge clk) begin : drv
    if (rst) begin
      s_tvalid <= 1'b0;
      src_gap = 0;
    end else begin
      if (s_tvalid && s_tready) drive_q.push_back(pid_step(cur_item));
      if (!s_tvalid || s_tready) begin
        if (src_gap > 0) begin
          src_gap--;
          s_tvalid <= 1'b0;
        end else if (pending.size() > 0) begin
          cur_item = pending.pop_front();
          s_tvalid <= 1'b1;
          s_tdata <= {cur_item.tgt, cur_item.meas};
          s_tuser <= cur_item.op;
          src_gap = src_idle ? $urandom_range(0, 19) : 0;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // sink side and result check
  always @(posedge clk) begin : mon
    drive_res_t want;
    if (rst) begin
      m_tready <= 1'b0;
      snk_gap = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (drive_q.size() == 0) begin
          report("unexpected result, drive", 64'sd0,
                 longint'($signed(m_tdata[DRIVE_W-1:0])));
        end else begin
          want = drive_q.pop_front();
          n_checked++;
          if (want.limited) n_limited++;
          if (m_tdata[DRIVE_W-1:0] !== want.drive)
            report("drive", longint'(want.drive), longint'($signed(m_tdata[DRIVE_W-1:0])));
          if (m_tuser !== want.limited)
            report("limited", longint'(want.limited), longint'(m_tuser));
        end
        snk_gap = snk_idle ? $urandom_range(0, 19) : 0;
      end
      if (snk_gap > 0) begin
        snk_gap--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : watchdog
    cycles++;
    if (cycles > LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, n_pushed - n_checked);
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin : stim
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // register defaults: all gains zero
    src_idle = 1'b1;
    snk_idle = 1'b1;
    push(OP_STEP, 16'sh8000, 16'sh7FFF);
    push(OP_STEP, 16'sh7FFF, 16'sh8000);
    push(OP_CLEAR, 16'sh7FFF, 16'sh7FFF);
    wait_idle();

    // drive landing exactly on the bound, then just past it
    set_reg(REG_GAIN_P, 21'd256);
    set_reg(REG_GAIN_I, '0);
    set_reg(REG_GAIN_D, '0);
    set_reg(REG_MODE, CFG_DATA_W'(MODE_POS));
    set_reg(REG_DRV_LIMIT, 21'd2560);
    set_reg(REG_INT_LIMIT, 21'd128);
    end_cfg();
    src_idle = 1'b0;
    push(OP_STEP, 16'sd0, 16'sd10);
    push(OP_STEP, 16'sd0, 16'sd11);
    push(OP_STEP, 16'sd0, -16'sd10);
    push(OP_STEP, 16'sd0, -16'sd11);
    wait_idle();

    // zero drive bound
    set_reg(REG_DRV_LIMIT, '0);
    end_cfg();
    push(OP_STEP, 16'sd5, 16'sd5);
    push(OP_STEP, 16'sd0, 16'sd1);
    wait_idle();

    // extreme gains and errors, widest limits
    set_reg(REG_GAIN_P, 21'h8000);
    set_reg(REG_GAIN_I, 21'h7FFF);
    set_reg(REG_GAIN_D, 21'h8000);
    set_reg(REG_MODE, CFG_DATA_W'(MODE_INCR));
    set_reg(REG_DRV_LIMIT, '1);
    set_reg(REG_INT_LIMIT, '1);
    end_cfg();
    snk_idle = 1'b0;
    push(OP_STEP, 16'sh8000, 16'sh7FFF);
    push(OP_STEP, 16'sh7FFF, 16'sh8000);
    push(OP_STEP, 16'sd0, 16'sd0);
    push(OP_CLEAR, 16'sh8000, 16'sh8000);
    wait_idle();

    // mode switches carry the shared state over
    set_reg(REG_GAIN_P, 21'd256);
    set_reg(REG_GAIN_I, 21'd16);
    set_reg(REG_GAIN_D, 21'd64);
    set_reg(REG_DRV_LIMIT, 21'd1664000);
    end_cfg();
    src_idle = 1'b1;
    push(OP_STEP, 16'sd100, 16'sd120);
    push(OP_STEP, 16'sd100, 16'sd90);
    push(OP_STEP, -16'sd50, 16'sd0);
    wait_idle();
    set_reg(REG_MODE, CFG_DATA_W'(MODE_POS));
    set_reg(REG_INT_LIMIT, '0);
    end_cfg();
    push(OP_STEP, 16'sd10, 16'sd30);
    push(OP_STEP, 16'sd10, -16'sd30);
    push(OP_STEP, 16'sd0, 16'sd0);
    wait_idle();
    set_reg(REG_MODE, CFG_DATA_W'(MODE_INCR));
    end_cfg();
    push(OP_STEP, 16'sd1, 16'sd2);
    push(OP_STEP, 16'sd3, 16'sd1);
    wait_idle();

    // error sum winds up hard in both directions and walks back
    set_reg(REG_GAIN_P, '0);
    set_reg(REG_GAIN_I, 21'd1);
    set_reg(REG_GAIN_D, '0);
    set_reg(REG_MODE, CFG_DATA_W'(MODE_POS));
    set_reg(REG_DRV_LIMIT, '1);
    set_reg(REG_INT_LIMIT, '1);
    end_cfg();
    src_idle = 1'b0;
    snk_idle = 1'b0;
    push(OP_CLEAR, 16'sd0, 16'sd0);
    repeat (SAT_RUN) push(OP_STEP, 16'sh8000, 16'sh7FFF);
    repeat (SAT_RET) push(OP_STEP, 16'sh7FFF, 16'sh8000);
    repeat (SAT_RUN) push(OP_STEP, 16'sh7FFF, 16'sh8000);
    repeat (SAT_RET) push(OP_STEP, 16'sh8000, 16'sh7FFF);
    wait_idle();

    // random settings, each followed by a run of random samples
    repeat (13) begin
      set_reg(REG_GAIN_P, CFG_DATA_W'(rand_gain()));
      set_reg(REG_GAIN_I, CFG_DATA_W'(rand_gain()));
      set_reg(REG_GAIN_D, CFG_DATA_W'(rand_gain()));
      set_reg(REG_MODE, CFG_DATA_W'($urandom_range(0, 1) ? MODE_POS : MODE_INCR));
      set_reg(REG_DRV_LIMIT, rand_limit());
      set_reg(REG_INT_LIMIT, rand_limit());
      end_cfg();
      src_idle = ($urandom_range(0, 2) != 0);
      snk_idle = ($urandom_range(0, 2) != 0);
      repeat (90) push_random();
      wait_idle();
    end

    if (drive_q.size() != 0) begin
      errors++;
      $display("%0t: %0d expected results never arrived", $time, drive_q.size());
    end
    $display("Ran %0d samples (%0d clears) across %0d register settings in both forms;",
             n_pushed, n_clears, n_settings);
    $display("%0d results checked, %0d of them clamped, %0d mismatches.",
             n_checked, n_limited, errors);
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+hdl
hdl/pidsc_pkg.sv
hdl/pidsc_cfg.sv
hdl/pidsc_core.sv
hdl/pid_speed_controller.sv
tb/sv/tb_pid_speed_controller.sv
